@@ hw/rtl/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg
// Shared widths, register map, reset values and the IF filter code table for
// the RSSI sweep scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

    localparam int FREQ_W     = 20;
    localparam int RSSI_W     = 8;
    localparam int COUNT_BITS = 16;
    localparam int SUM_W      = 24;
    localparam int CODE_W     = 8;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 4;
    localparam int REG_IDX_W  = 2;
    localparam int DIV_STEPS  = SUM_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam logic [REG_IDX_W-1:0] REG_START = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_END   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SPP   = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP  = 2'd3;

    localparam logic [FREQ_W-1:0]     START_RST = 20'd413000;
    localparam logic [FREQ_W-1:0]     END_RST   = 20'd463000;
    localparam logic [COUNT_BITS-1:0] SPP_RST   = 16'd500;
    localparam logic [FREQ_W-1:0]     STEP_RST  = 20'd50;

    localparam logic [RSSI_W-1:0] MAX_CLEAR = '0;
    localparam logic [RSSI_W-1:0] MIN_CLEAR = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_HOLD
    } rss_state_t;

    // IF bandwidth register byte picked from the step size.
    function automatic logic [CODE_W-1:0] filter_code(input logic [FREQ_W-1:0] step);
        logic [CODE_W-1:0] code;
        if (step < FREQ_W'(20))       code = 8'h32;
        else if (step < FREQ_W'(30))  code = 8'h22;
        else if (step < FREQ_W'(40))  code = 8'h26;
        else if (step < FREQ_W'(50))  code = 8'h12;
        else if (step < FREQ_W'(60))  code = 8'h15;
        else if (step < FREQ_W'(70))  code = 8'h01;
        else if (step < FREQ_W'(100)) code = 8'h03;
        else                          code = 8'h05;
        return code;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rssi_sweep_scanner_top.sv @@
// ----------------------------------------------------------------------------
// rssi_sweep_scanner_top
// Folds RSSI samples into per-point peak, floor and sum, and at the end of
// each point reports the point with its truncated mean, the next frequency and the IF filter code.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  sample    rssi_valid / rssi_ready, rssi              in
//  report    report_valid / report_ready, 6 fields      out
//  config    APB: psel penable pwrite paddr pwdata      in / prdata out
//
//  A sample that does not finish a point keeps the input ready. A sample that
//  finishes a point starts a restoring divide of the sum by the count, one
//  quotient bit per cycle on a single shared subtractor. When the divide is
//  done the hold state hands the report to the output register, waiting while
//  that register is full, and only then is the next sample taken.
//  The output register lets the next point's samples be taken while a report
//  waits; a second report waits in the divider until the first is taken.
//  Reset is asynchronous and active low; any register write restarts the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module rssi_sweep_scanner_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [rss_pkg::APB_AW-1:0]       paddr,
    input  wire logic [rss_pkg::APB_DW-1:0]       pwdata,
    output logic      [rss_pkg::APB_DW-1:0]       prdata,
    output logic                                  pready,
    input  wire logic                             rssi_valid,
    output logic                                  rssi_ready,
    input  wire logic [rss_pkg::RSSI_W-1:0]       rssi,
    output logic                                  report_valid,
    input  wire logic                             report_ready,
    output logic      [rss_pkg::FREQ_W-1:0]       point_freq_khz,
    output logic      [rss_pkg::RSSI_W-1:0]       peak_rssi,
    output logic      [rss_pkg::RSSI_W-1:0]       mean_rssi,
    output logic      [rss_pkg::RSSI_W-1:0]       floor_rssi,
    output logic      [rss_pkg::FREQ_W-1:0]       next_freq_khz,
    output logic      [rss_pkg::CODE_W-1:0]       if_filter_code
);
    import rss_pkg::*;

    // Configuration registers
    logic [FREQ_W-1:0]     start_reg, start_next;
    logic [FREQ_W-1:0]     end_reg, end_next;
    logic [COUNT_BITS-1:0] spp_reg, spp_next;
    logic [FREQ_W-1:0]     step_reg, step_next;

    // Point statistics
    logic [FREQ_W-1:0]     freq_reg, freq_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [RSSI_W-1:0]     max_reg, max_next;
    logic [RSSI_W-1:0]     min_reg, min_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;

    // Divider and pending report
    rss_state_t            state_reg, state_next;
    logic [STEP_W-1:0]     div_step_reg, div_step_next;
    logic [COUNT_BITS-1:0] divisor_reg, divisor_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [FREQ_W-1:0]     pend_freq_reg, pend_freq_next;
    logic [RSSI_W-1:0]     pend_max_reg, pend_max_next;
    logic [RSSI_W-1:0]     pend_min_reg, pend_min_next;
    logic [FREQ_W-1:0]     pend_nfreq_reg, pend_nfreq_next;
    logic [CODE_W-1:0]     pend_code_reg, pend_code_next;

    // Output register
    logic                  ovalid_reg, ovalid_next;
    logic [FREQ_W-1:0]     ofreq_reg, ofreq_next;
    logic [RSSI_W-1:0]     omax_reg, omax_next;
    logic [RSSI_W-1:0]     omean_reg, omean_next;
    logic [RSSI_W-1:0]     omin_reg, omin_next;
    logic [FREQ_W-1:0]     onfreq_reg, onfreq_next;
    logic [CODE_W-1:0]     ocode_reg, ocode_next;

    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  cfg_idx;
    logic                  in_beat;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic [SUM_W-1:0]      sum_inc;
    logic [RSSI_W-1:0]     max_upd;
    logic [RSSI_W-1:0]     min_upd;
    logic [COUNT_BITS-1:0] target;
    logic                  point_done;
    logic [FREQ_W:0]       freq_sum;
    logic [FREQ_W-1:0]     freq_wrap;
    logic [COUNT_BITS:0]   trial_rem;
    logic [COUNT_BITS:0]   trial_diff;
    logic                  slot_free;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_comb
    begin
        unique case (cfg_idx)
            REG_START: prdata = APB_DW'(start_reg);
            REG_END:   prdata = APB_DW'(end_reg);
            REG_SPP:   prdata = APB_DW'(spp_reg);
            REG_STEP:  prdata = APB_DW'(step_reg);
            default:   prdata = '0;
        endcase
    end

    assign rssi_ready = (state_reg == ST_IDLE);
    assign in_beat    = rssi_valid && rssi_ready;

    assign cnt_inc    = count_reg + COUNT_BITS'(1);
    assign sum_inc    = sum_reg + SUM_W'(rssi);
    assign max_upd    = (rssi > max_reg) ? rssi : max_reg;
    assign min_upd    = (rssi < min_reg) ? rssi : min_reg;
    assign target     = (spp_reg == '0) ? COUNT_BITS'(1) : spp_reg;
    assign point_done = (cnt_inc >= target) || (cnt_inc == '1);

    assign freq_sum   = {1'b0, freq_reg} + {1'b0, step_reg};
    assign freq_wrap  = (freq_sum > {1'b0, end_reg}) ? start_reg : freq_sum[FREQ_W-1:0];

    // One restoring divide step: shift in the next dividend bit and try the divisor.
    assign trial_rem  = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_diff = trial_rem - {1'b0, divisor_reg};

    assign slot_free  = !ovalid_reg || report_ready;

    always_comb
    begin
        start_next      = start_reg;
        end_next        = end_reg;
        spp_next        = spp_reg;
        step_next       = step_reg;
        freq_next       = freq_reg;
        count_next      = count_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        sum_next        = sum_reg;
        state_next      = state_reg;
        div_step_next   = div_step_reg;
        divisor_next    = divisor_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        pend_freq_next  = pend_freq_reg;
        pend_max_next   = pend_max_reg;
        pend_min_next   = pend_min_reg;
        pend_nfreq_next = pend_nfreq_reg;
        pend_code_next  = pend_code_reg;
        ovalid_next     = ovalid_reg && !report_ready;
        ofreq_next      = ofreq_reg;
        omax_next       = omax_reg;
        omean_next      = omean_reg;
        omin_next       = omin_reg;
        onfreq_next     = onfreq_reg;
        ocode_next      = ocode_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (point_done)
                    begin
                        pend_freq_next  = freq_reg;
                        pend_max_next   = max_upd;
                        pend_min_next   = min_upd;
                        pend_nfreq_next = freq_wrap;
                        pend_code_next  = filter_code(step_reg);
                        divisor_next    = cnt_inc;
                        quo_next        = sum_inc;
                        rem_next        = '0;
                        div_step_next   = '0;
                        freq_next       = freq_wrap;
                        count_next      = '0;
                        max_next        = MAX_CLEAR;
                        min_next        = MIN_CLEAR;
                        sum_next        = '0;
                        state_next      = ST_DIVIDE;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                        max_next   = max_upd;
                        min_next   = min_upd;
                        sum_next   = sum_inc;
                    end
                end
            end
            ST_DIVIDE:
            begin
                if (trial_diff[COUNT_BITS])
                begin
                    rem_next = trial_rem[COUNT_BITS-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                else
                begin
                    rem_next = trial_diff[COUNT_BITS-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                div_step_next = div_step_reg + STEP_W'(1);
                if (div_step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ofreq_next  = pend_freq_reg;
                    omax_next   = pend_max_reg;
                    omean_next  = quo_reg[RSSI_W-1:0];
                    omin_next   = pend_min_reg;
                    onfreq_next = pend_nfreq_reg;
                    ocode_next  = pend_code_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Writes should arrive only while idle; the block does not enforce this. Each one restarts the sweep.
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_START: start_next = pwdata[FREQ_W-1:0];
                REG_END:   end_next   = pwdata[FREQ_W-1:0];
                REG_SPP:   spp_next   = pwdata[COUNT_BITS-1:0];
                REG_STEP:  step_next  = pwdata[FREQ_W-1:0];
                default:   start_next = start_reg;
            endcase
            freq_next  = (cfg_idx == REG_START) ? pwdata[FREQ_W-1:0] : start_reg;
            count_next = '0;
            max_next   = MAX_CLEAR;
            min_next   = MIN_CLEAR;
            sum_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= START_RST;
            end_reg      <= END_RST;
            spp_reg      <= SPP_RST;
            step_reg     <= STEP_RST;
            freq_reg     <= START_RST;
            count_reg    <= '0;
            max_reg      <= MAX_CLEAR;
            min_reg      <= MIN_CLEAR;
            sum_reg      <= '0;
            state_reg    <= ST_IDLE;
            div_step_reg <= '0;
            ovalid_reg   <= 1'b0;
        end
        else
        begin
            start_reg    <= start_next;
            end_reg      <= end_next;
            spp_reg      <= spp_next;
            step_reg     <= step_next;
            freq_reg     <= freq_next;
            count_reg    <= count_next;
            max_reg      <= max_next;
            min_reg      <= min_next;
            sum_reg      <= sum_next;
            state_reg    <= state_next;
            div_step_reg <= div_step_next;
            ovalid_reg   <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg    <= divisor_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        pend_freq_reg  <= pend_freq_next;
        pend_max_reg   <= pend_max_next;
        pend_min_reg   <= pend_min_next;
        pend_nfreq_reg <= pend_nfreq_next;
        pend_code_reg  <= pend_code_next;
        ofreq_reg      <= ofreq_next;
        omax_reg       <= omax_next;
        omean_reg      <= omean_next;
        omin_reg       <= omin_next;
        onfreq_reg     <= onfreq_next;
        ocode_reg      <= ocode_next;
    end

    assign report_valid   = ovalid_reg;
    assign point_freq_khz = ofreq_reg;
    assign peak_rssi      = omax_reg;
    assign mean_rssi      = omean_reg;
    assign floor_rssi     = omin_reg;
    assign next_freq_khz  = onfreq_reg;
    assign if_filter_code = ocode_reg;

endmodule

`default_nettype wire
